// ===== hdl/crs_pkg.sv =====
// ----------------------------------------------------------------------------
// crs_pkg: shared types and constants for the corner response suppressor
// item layouts, keypoint entry layout, the token passed along the cell chain,
// status and kind codes
// ----------------------------------------------------------------------------
package crs_pkg;

	localparam int COORD_W = 12;
	localparam int RESP_W  = 8;
	localparam int SLOT_W  = 8;
	localparam int CNT_OUT_W = 9;
	localparam int DIAM_W  = 6;
	localparam int LIM_W   = 2 * DIAM_W;

	localparam logic [RESP_W-1:0] MIN_RESPONSE_RESET = 8'd100;
	localparam logic [DIAM_W-1:0] DIAMETER_RESET     = 6'd6;

	// item kinds
	localparam logic [1:0] KIND_PIXEL = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	// result status codes
	localparam logic [2:0] ST_BELOW      = 3'd0;
	localparam logic [2:0] ST_ADDED      = 3'd1;
	localparam logic [2:0] ST_REPLACED   = 3'd2;
	localparam logic [2:0] ST_SUPPRESSED = 3'd3;
	localparam logic [2:0] ST_FULL       = 3'd4;
	localparam logic [2:0] ST_READ       = 3'd5;
	localparam logic [2:0] ST_CLEARED    = 3'd6;

	// configuration register indexes
	localparam logic REG_MIN_RESPONSE = 1'b0;
	localparam logic REG_DIAMETER     = 1'b1;

	typedef struct packed {
		logic [1:0]         kind;
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
		logic [RESP_W-1:0]  response;
		logic [SLOT_W-1:0]  read_slot;
	} in_item_t;

	typedef struct packed {
		logic [2:0]           status;
		logic [SLOT_W-1:0]    slot;
		logic [COORD_W-1:0]   out_x;
		logic [COORD_W-1:0]   out_y;
		logic [RESP_W-1:0]    out_response;
		logic [CNT_OUT_W-1:0] count;
	} out_item_t;

	typedef struct packed {
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [RESP_W-1:0]  strength;
	} entry_t;

	// token walking the cell chain, one cell per cycle
	typedef struct packed {
		logic               active;
		logic               is_read;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [RESP_W-1:0]  resp;
		logic [SLOT_W-1:0]  slot;    // read slot, or slot replaced
		logic               overlap;
		logic               hit;     // entry replaced, or read slot found
		entry_t             rdata;
	} token_t;

endpackage

// ===== hdl/crs_cell.sv =====
// ----------------------------------------------------------------------------
// crs_cell: one keypoint slot of the suppression chain
// holds one entry, tests the passing token against it and hands the token on
// ----------------------------------------------------------------------------
module crs_cell #(
	parameter int MAX_KEYPOINTS = 256,
	parameter int INDEX = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  crs_pkg::token_t               tok_in,
	output crs_pkg::token_t               tok_out,
	input  logic [$clog2(MAX_KEYPOINTS+1)-1:0] count,
	input  logic [crs_pkg::DIAM_W-1:0]    diameter,
	input  logic [crs_pkg::LIM_W-1:0]     lim,
	input  logic                          app_we,
	input  crs_pkg::entry_t               app_data
);

	localparam int CNT_W = $clog2(MAX_KEYPOINTS + 1);

	crs_pkg::entry_t entry_q;
	crs_pkg::token_t tok_q;
	crs_pkg::token_t tok_nxt;

	logic                         in_use;
	logic [crs_pkg::COORD_W-1:0]  dx, dy;
	logic [crs_pkg::LIM_W-1:0]    sqx, sqy;
	logic [crs_pkg::LIM_W:0]      dsq;
	logic                         overlap;
	logic                         replace;
	logic                         read_hit;

	always_comb begin
		in_use = count > CNT_W'(INDEX);
		dx = (tok_in.x > entry_q.col) ? tok_in.x - entry_q.col : entry_q.col - tok_in.x;
		dy = (tok_in.y > entry_q.row) ? tok_in.y - entry_q.row : entry_q.row - tok_in.y;
		// small squares only matter once both offsets are under the diameter
		sqx = crs_pkg::LIM_W'(dx[crs_pkg::DIAM_W-1:0]) * crs_pkg::LIM_W'(dx[crs_pkg::DIAM_W-1:0]);
		sqy = crs_pkg::LIM_W'(dy[crs_pkg::DIAM_W-1:0]) * crs_pkg::LIM_W'(dy[crs_pkg::DIAM_W-1:0]);
		dsq = {1'b0, sqx} + {1'b0, sqy};
		overlap = in_use
			&& (dx < crs_pkg::COORD_W'(diameter))
			&& (dy < crs_pkg::COORD_W'(diameter))
			&& (dsq < {1'b0, lim});
		replace = tok_in.active && !tok_in.is_read && !tok_in.hit && overlap
			&& (tok_in.resp > entry_q.strength);
		read_hit = tok_in.active && tok_in.is_read && in_use
			&& (int'(tok_in.slot) == INDEX);

		tok_nxt = tok_in;
		if (tok_in.active && !tok_in.is_read && !tok_in.hit && overlap) begin
			tok_nxt.overlap = 1'b1;
		end
		if (replace) begin
			tok_nxt.hit = 1'b1;
			tok_nxt.slot = crs_pkg::SLOT_W'(INDEX);
		end
		if (read_hit) begin
			tok_nxt.hit = 1'b1;
			tok_nxt.rdata = entry_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (replace) begin
			entry_q.col <= tok_in.x;
			entry_q.row <= tok_in.y;
			entry_q.strength <= tok_in.resp;
		end else if (app_we) begin
			entry_q <= app_data;
		end
	end

	assign tok_out = tok_q;

endmodule

// ===== hdl/corner_response_suppressor.sv =====
// ----------------------------------------------------------------------------
// corner_response_suppressor: keypoint table with non-maximum suppression
// pixel responses over threshold are matched against a chain of keypoint cells
// ----------------------------------------------------------------------------
// Items are taken with start while busy is low; every item gives exactly one
// result, shown on result for one cycle with done high, and the receiver cannot
// hold it off. Clear items, unused kinds and pixels at or below min_response
// answer on the next cycle and leave busy low, so they can follow one per
// cycle. A pixel over threshold and a table read send a token down the chain
// of MAX_KEYPOINTS cells, one cell per cycle, from the launch register to
// the result register, and busy is high until the cycle the result is shown.
// Every slot is visited in table order, so the first weaker overlapping
// keypoint is the one replaced. Configuration writes land at once and are
// meant for idle times.
// ----------------------------------------------------------------------------
module corner_response_suppressor #(
	parameter int MAX_KEYPOINTS = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// item side
	input  logic                        start,
	output logic                        busy,
	input  crs_pkg::in_item_t           item,
	// result side
	output logic                        done,
	output crs_pkg::out_item_t          result,
	// configuration
	input  logic                        cfg_we,
	input  logic                        cfg_addr,
	input  logic [crs_pkg::RESP_W-1:0]  cfg_wdata
);

	localparam int CNT_W = $clog2(MAX_KEYPOINTS + 1);
	localparam int IDX_W = $clog2(MAX_KEYPOINTS);

	typedef enum logic {
		S_IDLE,
		S_RUN
	} state_t;

	state_t                         state_q;
	logic                           done_q;
	crs_pkg::out_item_t             result_q;
	logic [CNT_W-1:0]               count_q;
	crs_pkg::token_t                launch_q;

	// configuration registers, squared diameter kept alongside
	logic [crs_pkg::RESP_W-1:0]     min_resp_q;
	logic [crs_pkg::DIAM_W-1:0]     diam_q;
	logic [crs_pkg::LIM_W-1:0]      lim_q;

	crs_pkg::token_t                chain [0:MAX_KEYPOINTS];
	logic [MAX_KEYPOINTS:0]         chain_act;
	crs_pkg::token_t                tail;

	logic                           accept;
	logic                           tail_append;
	crs_pkg::entry_t                app_data;
	crs_pkg::out_item_t             fin_result;
	logic [CNT_W-1:0]               fin_count;
	logic [31:0]                    cnt_wide;
	logic [31:0]                    slot_wide;
	logic [31:0]                    fin_cnt_wide;
	crs_pkg::out_item_t             quick_result;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// the cell chain, token enters at cell 0 from the launch register
	assign chain[0] = launch_q;
	assign tail     = chain[MAX_KEYPOINTS];

	// append goes into the first free slot when the token finishes clean
	assign tail_append = tail.active && !tail.is_read && !tail.hit && !tail.overlap
		&& (count_q < CNT_W'(MAX_KEYPOINTS));

	always_comb begin
		app_data.col      = tail.x;
		app_data.row      = tail.y;
		app_data.strength = tail.resp;
	end

	for (genvar i = 0; i < MAX_KEYPOINTS; i++) begin : g_cell
		logic cell_we;
		assign cell_we = tail_append && (count_q[IDX_W-1:0] == IDX_W'(i));

		crs_cell #(
			.MAX_KEYPOINTS (MAX_KEYPOINTS),
			.INDEX         (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.tok_in   (chain[i]),
			.tok_out  (chain[i+1]),
			.count    (count_q),
			.diameter (diam_q),
			.lim      (lim_q),
			.app_we   (cell_we),
			.app_data (app_data)
		);
	end

	for (genvar i = 0; i <= MAX_KEYPOINTS; i++) begin : g_act
		assign chain_act[i] = chain[i].active;
	end

	// result of a token leaving the chain
	always_comb begin
		fin_result = '0;
		fin_count  = count_q;
		slot_wide  = 32'(count_q);
		if (tail.is_read) begin
			// rdata stays zero unless a live slot matched
			fin_result.status       = crs_pkg::ST_READ;
			fin_result.slot         = tail.slot;
			fin_result.out_x        = tail.rdata.col;
			fin_result.out_y        = tail.rdata.row;
			fin_result.out_response = tail.rdata.strength;
		end else if (tail.hit) begin
			fin_result.status = crs_pkg::ST_REPLACED;
			fin_result.slot   = tail.slot;
		end else if (tail.overlap) begin
			fin_result.status = crs_pkg::ST_SUPPRESSED;
		end else if (!tail_append) begin
			fin_result.status = crs_pkg::ST_FULL;
		end else begin
			fin_result.status = crs_pkg::ST_ADDED;
			fin_result.slot   = slot_wide[crs_pkg::SLOT_W-1:0];
			fin_count         = count_q + CNT_W'(1);
		end
		fin_cnt_wide     = 32'(fin_count);
		fin_result.count = fin_cnt_wide[crs_pkg::CNT_OUT_W-1:0];
	end

	// answer for items that never enter the chain
	always_comb begin
		quick_result = '0;
		cnt_wide     = 32'(count_q);
		case (item.kind)
			crs_pkg::KIND_CLEAR: begin
				quick_result.status = crs_pkg::ST_CLEARED;
			end
			default: begin
				// unused kind, or pixel at or below threshold
				quick_result.status = crs_pkg::ST_BELOW;
				quick_result.count  = cnt_wide[crs_pkg::CNT_OUT_W-1:0];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			result_q <= '0;
			count_q  <= '0;
			launch_q <= '0;
		end else begin
			done_q          <= 1'b0;
			launch_q.active <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if ((item.kind == crs_pkg::KIND_READ)
								|| ((item.kind == crs_pkg::KIND_PIXEL)
								&& (item.response > min_resp_q))) begin
							// launch a token down the chain
							launch_q.active  <= 1'b1;
							launch_q.is_read <= (item.kind == crs_pkg::KIND_READ);
							launch_q.x       <= item.pixel_x;
							launch_q.y       <= item.pixel_y;
							launch_q.resp    <= item.response;
							launch_q.slot    <= item.read_slot;
							launch_q.overlap <= 1'b0;
							launch_q.hit     <= 1'b0;
							launch_q.rdata   <= '0;
							state_q          <= S_RUN;
						end else begin
							done_q   <= 1'b1;
							result_q <= quick_result;
							if (item.kind == crs_pkg::KIND_CLEAR) begin
								count_q <= '0;
							end
						end
					end
				end
				S_RUN: begin
					if (tail.active) begin
						done_q   <= 1'b1;
						result_q <= fin_result;
						count_q  <= fin_count;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_resp_q <= crs_pkg::MIN_RESPONSE_RESET;
			diam_q     <= crs_pkg::DIAMETER_RESET;
			lim_q      <= crs_pkg::LIM_W'(crs_pkg::DIAMETER_RESET)
				* crs_pkg::LIM_W'(crs_pkg::DIAMETER_RESET);
		end else if (cfg_we) begin
			case (cfg_addr)
				crs_pkg::REG_MIN_RESPONSE: begin
					min_resp_q <= cfg_wdata;
				end
				crs_pkg::REG_DIAMETER: begin
					diam_q <= cfg_wdata[crs_pkg::DIAM_W-1:0];
					lim_q  <= crs_pkg::LIM_W'(cfg_wdata[crs_pkg::DIAM_W-1:0])
						* crs_pkg::LIM_W'(cfg_wdata[crs_pkg::DIAM_W-1:0]);
				end
				default: begin
					min_resp_q <= min_resp_q;
				end
			endcase
		end
	end

	// no result while a token is still walking
	a_no_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !done)
		else $error("result shown while chain busy");

	// at most one token in the chain
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(chain_act))
		else $error("more than one token in chain");

	// a token leaving the chain yields a result next cycle
	a_tail_done: assert property (@(posedge clk) disable iff (!arst_n)
		tail.active |=> done)
		else $error("finished token gave no result");

	// table fill never passes capacity
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_KEYPOINTS))
		else $error("keypoint count over capacity");

endmodule
